### sv/vfsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vfsc_pkg
// Shared widths, register indexes and result codes of the sphere classifier.
// ----------------------------------------------------------------------------
package vfsc_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int RADIUS_WIDTH = 31;
    localparam int AXIS_BITS = 20;
    localparam int AXIS_FRAC = 18;
    localparam int SLOPE_FRAC = 12;
    localparam int SLOPE_BITS = 16;
    localparam int DIST_BITS = 32;
    localparam int CFG_DATA_WIDTH = 64;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int AXIS_REG_WIDTH = 3 * AXIS_BITS;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_CAM_POS_X,
        REG_CAM_POS_Y,
        REG_CAM_POS_Z,
        REG_RIGHT_AXIS,
        REG_UP_AXIS,
        REG_BACK_AXIS,
        REG_NEAR_FAR,
        REG_SLOPES_FACTORS
    } reg_index_t;

    typedef enum logic [1:0] {
        CLS_OUTSIDE,
        CLS_INSIDE,
        CLS_INTERSECT
    } cls_t;

endpackage
`default_nettype wire

### sv/vfsc_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vfsc_if
// Valid/ready channels carrying sphere requests and classification results.
// ----------------------------------------------------------------------------
interface vfsc_sphere_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [vfsc_pkg::COORD_WIDTH-1:0] center_x;
    logic signed [vfsc_pkg::COORD_WIDTH-1:0] center_y;
    logic signed [vfsc_pkg::COORD_WIDTH-1:0] center_z;
    logic [vfsc_pkg::RADIUS_WIDTH-1:0]       radius;

    modport source (output valid, center_x, center_y, center_z, radius, input ready);
    modport sink (input valid, center_x, center_y, center_z, radius, output ready);
endinterface

interface vfsc_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] classification;

    modport source (output valid, classification, input ready);
    modport sink (input valid, classification, output ready);
endinterface
`default_nettype wire

### sv/view_frustum_sphere_classifier.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// view_frustum_sphere_classifier
// Classifies a sphere as outside, inside or intersecting the view frustum.
// ----------------------------------------------------------------------------
// The block accepts one sphere request per clock cycle and passes it through
// a five-stage pipeline to its classification output:
// the camera offset, the nine axis products, the projections, the slope and
// radius products with the depth tests, and the lateral tests into the output
// register. Empty stages close up under back-pressure, so the input stalls only
// when every stage holds a request and the output is not being taken. Camera
// registers should be written only while the pipeline is empty.
// ----------------------------------------------------------------------------
module view_frustum_sphere_classifier
(
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    cfg_we,
    input  wire logic [vfsc_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  wire logic [vfsc_pkg::CFG_DATA_WIDTH-1:0]     cfg_data,
    vfsc_sphere_if.sink                                  sphere,
    vfsc_result_if.source                                result
);

    localparam int VW = vfsc_pkg::COORD_WIDTH + 1;
    localparam int PW = VW + vfsc_pkg::AXIS_BITS;
    localparam int DW = PW + 3;
    localparam int AW = DW - vfsc_pkg::AXIS_FRAC;
    localparam int ZW = AW + vfsc_pkg::SLOPE_BITS + 1;
    localparam int RW = vfsc_pkg::RADIUS_WIDTH;
    localparam int FW = vfsc_pkg::SLOPE_BITS + RW;
    localparam int SW = AW + vfsc_pkg::SLOPE_FRAC;
    localparam int CW = ZW + 3;
    localparam int BW = vfsc_pkg::DIST_BITS + 8;
    localparam int XB = vfsc_pkg::AXIS_BITS;
    localparam int SB = vfsc_pkg::SLOPE_BITS;

    // Configuration registers
    logic signed [vfsc_pkg::COORD_WIDTH-1:0]    cam_x_reg, cam_y_reg, cam_z_reg;
    logic [vfsc_pkg::AXIS_REG_WIDTH-1:0]        right_reg, up_reg, back_reg;
    logic [vfsc_pkg::CFG_DATA_WIDTH-1:0]        near_far_reg, slopes_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_x_reg    <= '0;
            cam_y_reg    <= '0;
            cam_z_reg    <= '0;
            right_reg    <= '0;
            up_reg       <= '0;
            back_reg     <= '0;
            near_far_reg <= '0;
            slopes_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (vfsc_pkg::reg_index_t'(cfg_index))
                vfsc_pkg::REG_CAM_POS_X:
                    cam_x_reg <= cfg_data[vfsc_pkg::COORD_WIDTH-1:0];
                vfsc_pkg::REG_CAM_POS_Y:
                    cam_y_reg <= cfg_data[vfsc_pkg::COORD_WIDTH-1:0];
                vfsc_pkg::REG_CAM_POS_Z:
                    cam_z_reg <= cfg_data[vfsc_pkg::COORD_WIDTH-1:0];
                vfsc_pkg::REG_RIGHT_AXIS:
                    right_reg <= cfg_data[vfsc_pkg::AXIS_REG_WIDTH-1:0];
                vfsc_pkg::REG_UP_AXIS:
                    up_reg <= cfg_data[vfsc_pkg::AXIS_REG_WIDTH-1:0];
                vfsc_pkg::REG_BACK_AXIS:
                    back_reg <= cfg_data[vfsc_pkg::AXIS_REG_WIDTH-1:0];
                vfsc_pkg::REG_NEAR_FAR:
                    near_far_reg <= cfg_data;
                vfsc_pkg::REG_SLOPES_FACTORS:
                    slopes_reg <= cfg_data;
                default:
                    near_far_reg <= near_far_reg;
            endcase
        end
    end

    // Pipeline control: a stage loads when it is empty or the next one loads.
    logic vld1_reg, vld2_reg, vld3_reg, vld4_reg, out_vld_reg;
    logic en1, en2, en3, en4, en5;

    assign en5 = !out_vld_reg || result.ready;
    assign en4 = !vld4_reg || en5;
    assign en3 = !vld3_reg || en4;
    assign en2 = !vld2_reg || en3;
    assign en1 = !vld1_reg || en2;
    assign sphere.ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg    <= 1'b0;
            vld2_reg    <= 1'b0;
            vld3_reg    <= 1'b0;
            vld4_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                vld1_reg <= sphere.valid;
            if (en2)
                vld2_reg <= vld1_reg;
            if (en3)
                vld3_reg <= vld2_reg;
            if (en4)
                vld4_reg <= vld3_reg;
            if (en5)
                out_vld_reg <= vld4_reg;
        end
    end

    // Stage 1: offset from the camera
    logic signed [VW-1:0] vx_reg, vy_reg, vz_reg, vx_next, vy_next, vz_next;
    logic [RW-1:0]        r1_reg, r2_reg, r3_reg;

    assign vx_next = VW'(sphere.center_x) - VW'(cam_x_reg);
    assign vy_next = VW'(sphere.center_y) - VW'(cam_y_reg);
    assign vz_next = VW'(sphere.center_z) - VW'(cam_z_reg);

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            vx_reg <= vx_next;
            vy_reg <= vy_next;
            vz_reg <= vz_next;
            r1_reg <= sphere.radius;
        end
    end

    // Stage 2: the nine component products
    logic signed [PW-1:0] pr_reg [3], pu_reg [3], pb_reg [3];
    logic signed [PW-1:0] pr_next [3], pu_next [3], pb_next [3];
    logic signed [VW-1:0] vsel [3];

    assign vsel[0] = vx_reg;
    assign vsel[1] = vy_reg;
    assign vsel[2] = vz_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            pr_next[k] = vsel[k] * $signed(right_reg[k*XB +: XB]);
            pu_next[k] = vsel[k] * $signed(up_reg[k*XB +: XB]);
            pb_next[k] = vsel[k] * $signed(back_reg[k*XB +: XB]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            pr_reg <= pr_next;
            pu_reg <= pu_next;
            pb_reg <= pb_next;
            r2_reg <= r1_reg;
        end
    end

    // Stage 3: dot products, floored by dropping the 18 axis fraction bits
    logic signed [DW-1:0] dot_x, dot_y, dot_z, neg_z;
    logic signed [AW-1:0] ax_reg, ay_reg, az_reg;

    assign dot_x = DW'(pr_reg[0]) + DW'(pr_reg[1]) + DW'(pr_reg[2]);
    assign dot_y = DW'(pu_reg[0]) + DW'(pu_reg[1]) + DW'(pu_reg[2]);
    assign dot_z = DW'(pb_reg[0]) + DW'(pb_reg[1]) + DW'(pb_reg[2]);
    assign neg_z = -dot_z;

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            ax_reg <= dot_x[DW-1:vfsc_pkg::AXIS_FRAC];
            ay_reg <= dot_y[DW-1:vfsc_pkg::AXIS_FRAC];
            az_reg <= neg_z[DW-1:vfsc_pkg::AXIS_FRAC];
            r3_reg <= r2_reg;
        end
    end

    // Stage 4: slope and radius products, depth tests
    logic signed [ZW-1:0] zz1_reg, zz2_reg, zz1_next, zz2_next;
    logic [FW-1:0]        d1_reg, d2_reg, d1_next, d2_next;
    logic signed [SW-1:0] axs_reg, ays_reg;
    logic                 dep_out_reg, dep_cut_reg;
    logic signed [BW-1:0] az_w, far_hi, far_lo, near_hi, near_lo, near_w, far_w, r_w;
    logic                 dep_out_next, dep_cut_next;

    assign zz1_next = az_reg * $signed({1'b0, slopes_reg[SB +: SB]});
    assign zz2_next = az_reg * $signed({1'b0, slopes_reg[0 +: SB]});
    assign d1_next  = FW'(slopes_reg[2*SB +: SB]) * FW'(r3_reg);
    assign d2_next  = FW'(slopes_reg[3*SB +: SB]) * FW'(r3_reg);

    assign az_w    = BW'(az_reg);
    assign r_w     = $signed(BW'(r3_reg));
    assign near_w  = $signed(BW'(near_far_reg[0 +: vfsc_pkg::DIST_BITS]));
    assign far_w   = $signed(BW'(near_far_reg[vfsc_pkg::DIST_BITS +: vfsc_pkg::DIST_BITS]));
    assign far_hi  = far_w + r_w;
    assign far_lo  = far_w - r_w;
    assign near_hi = near_w + r_w;
    assign near_lo = near_w - r_w;
    assign dep_out_next = (az_w > far_hi) || (az_w < near_lo);
    assign dep_cut_next = (az_w > far_lo) || (az_w < near_hi);

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            zz1_reg     <= zz1_next;
            zz2_reg     <= zz2_next;
            d1_reg      <= d1_next;
            d2_reg      <= d2_next;
            axs_reg     <= {ax_reg, {vfsc_pkg::SLOPE_FRAC{1'b0}}};
            ays_reg     <= {ay_reg, {vfsc_pkg::SLOPE_FRAC{1'b0}}};
            dep_out_reg <= dep_out_next;
            dep_cut_reg <= dep_cut_next;
        end
    end

    // Stage 5: lateral tests and final classification
    logic signed [CW-1:0] z1, z2, e1, e2, sx_w, sy_w;
    logic                 lat_out, lat_cut;
    vfsc_pkg::cls_t       cls_next, cls_reg;

    assign z1   = CW'(zz1_reg);
    assign z2   = CW'(zz2_reg);
    assign e1   = $signed(CW'(d1_reg));
    assign e2   = $signed(CW'(d2_reg));
    assign sx_w = CW'(axs_reg);
    assign sy_w = CW'(ays_reg);

    assign lat_out = (sx_w > z1 + e1) || (sx_w < -z1 - e1)
                  || (sy_w > z2 + e2) || (sy_w < -z2 - e2);
    assign lat_cut = (sx_w > z1 - e1) || (sx_w < -z1 + e1)
                  || (sy_w > z2 - e2) || (sy_w < -z2 + e2);

    always_comb
    begin
        if (dep_out_reg || lat_out)
            cls_next = vfsc_pkg::CLS_OUTSIDE;
        else if (dep_cut_reg || lat_cut)
            cls_next = vfsc_pkg::CLS_INTERSECT;
        else
            cls_next = vfsc_pkg::CLS_INSIDE;
    end

    always_ff @(posedge clk)
    begin
        if (en5)
            cls_reg <= cls_next;
    end

    assign result.valid          = out_vld_reg;
    assign result.classification = cls_reg;

endmodule
`default_nettype wire

### sv/vfsc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vfsc_checker
// Port-level checks on the sphere classifier, bound to the top level.
// ----------------------------------------------------------------------------
module vfsc_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [1:0] classification
);

    // No result is shown while reset is held.
    a_reset_idle: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result valid during reset");

    // The input stalls only when the whole pipeline is held by the output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without output back-pressure");

    // Only the three defined codes appear.
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (classification == vfsc_pkg::CLS_OUTSIDE
                    || classification == vfsc_pkg::CLS_INSIDE
                    || classification == vfsc_pkg::CLS_INTERSECT))
        else $error("undefined classification code");

    // A held result keeps its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(classification)))
        else $error("held result changed or dropped");

endmodule

bind view_frustum_sphere_classifier vfsc_checker u_vfsc_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (sphere.ready),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .classification (result.classification)
);
`default_nettype wire

### dv/tb_view_frustum_sphere_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_view_frustum_sphere_classifier
// Self-checking bench for the sphere frustum classifier. A table of directed
// requests is run first, then phases of random requests under several camera
// set-ups and handshake idling patterns. Each classification is compared
// against the code held in its table row for typed rows, else against an
// in-bench fixed-point prediction taken when the request is accepted.
// ----------------------------------------------------------------------------
module tb_view_frustum_sphere_classifier;

    localparam int NUM_DIRECTED = 21;
    localparam int NUM_PHASES = 12;
    localparam int REQUESTS_PER_PHASE = 80;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT = 400000;

    typedef enum int {
        CAM_EXTREME_HIGH,
        CAM_EXTREME_LOW,
        CAM_AIMED,
        CAM_RAW
    } camera_kind_t;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed {
        logic signed [vfsc_pkg::COORD_WIDTH-1:0] cx;
        logic signed [vfsc_pkg::COORD_WIDTH-1:0] cy;
        logic signed [vfsc_pkg::COORD_WIDTH-1:0] cz;
        logic [vfsc_pkg::RADIUS_WIDTH-1:0]       rad;
        logic                                    aimed_camera;
        logic                                    typed;
        vfsc_pkg::cls_t                          cls;
    } sphere_row_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n;
    logic                                 cfg_we;
    logic [vfsc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [vfsc_pkg::CFG_DATA_WIDTH-1:0]  cfg_data;

    vfsc_sphere_if sphere_ch ();
    vfsc_result_if result_ch ();

    view_frustum_sphere_classifier dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sphere    (sphere_ch),
        .result    (result_ch)
    );

    logic [63:0]    camera_regs [8];
    vfsc_pkg::cls_t expected_cls [$];
    vfsc_pkg::cls_t expected_head;
    logic           hold_typed;
    vfsc_pkg::cls_t hold_cls;
    int             sender_idle_pct;
    int             recv_stall_pct;
    int             err_count = 0;
    int             cycle_count = 0;

    sphere_row_t directed_rows [NUM_DIRECTED] = '{
        '{32'sd0, 32'sd0, 32'sd0, 31'd0, 1'b0, 1'b1, vfsc_pkg::CLS_INSIDE},
        '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'd0, 1'b0, 1'b1,
          vfsc_pkg::CLS_INSIDE},
        '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 31'd0, 1'b0, 1'b1,
          vfsc_pkg::CLS_INSIDE},
        '{32'sd0, 32'sd0, 32'sd0, 31'h7FFF_FFFF, 1'b0, 1'b1, vfsc_pkg::CLS_INTERSECT},
        '{32'sh1234_5678, -32'sd5, 32'sd0, 31'h5555_5555, 1'b0, 1'b1,
          vfsc_pkg::CLS_INTERSECT},
        '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh5555_5555, 31'h2AAA_AAAA, 1'b0, 1'b1,
          vfsc_pkg::CLS_INTERSECT},
        '{32'sd0, 32'sd0, -32'sd655360, 31'd0, 1'b1, 1'b0, vfsc_pkg::CLS_OUTSIDE},
        '{32'sd0, 32'sd0, -32'sd13107200, 31'd0, 1'b1, 1'b0, vfsc_pkg::CLS_OUTSIDE},
        '{32'sd0, 32'sd0, -32'sd6553600, 31'd0, 1'b1, 1'b0, vfsc_pkg::CLS_OUTSIDE},
        '{32'sd0, 32'sd0, -32'sd65536, 31'd0, 1'b1, 1'b0, vfsc_pkg::CLS_OUTSIDE},
        '{32'sd0, 32'sd0, -32'sd32768, 31'd0, 1'b1, 1'b0, vfsc_pkg::CLS_OUTSIDE},
        '{32'sd655360, 32'sd0, -32'sd655360, 31'd0, 1'b1, 1'b0, vfsc_pkg::CLS_OUTSIDE},
        '{32'sd0, -32'sd655360, -32'sd655360, 31'd0, 1'b1, 1'b0, vfsc_pkg::CLS_OUTSIDE},
        '{32'sd720896, 32'sd0, -32'sd655360, 31'd0, 1'b1, 1'b0, vfsc_pkg::CLS_OUTSIDE},
        '{32'sd0, 32'sd0, -32'sd6684672, 31'd131072, 1'b1, 1'b0, vfsc_pkg::CLS_OUTSIDE},
        '{32'sd0, 32'sd0, -32'sd3276800, 31'd3932160, 1'b1, 1'b0,
          vfsc_pkg::CLS_OUTSIDE},
        '{32'sd0, 32'sd0, 32'sd327680, 31'd0, 1'b1, 1'b0, vfsc_pkg::CLS_OUTSIDE},
        '{32'sd0, 32'sd0, 32'sd327680, 31'd655360, 1'b1, 1'b0, vfsc_pkg::CLS_OUTSIDE},
        '{32'sd1966080, 32'sd0, -32'sd1310720, 31'd524288, 1'b1, 1'b0,
          vfsc_pkg::CLS_OUTSIDE},
        '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 1'b1, 1'b0,
          vfsc_pkg::CLS_OUTSIDE},
        '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 31'd0, 1'b1, 1'b0,
          vfsc_pkg::CLS_OUTSIDE}
    };

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint axis_part(vfsc_pkg::reg_index_t idx, int k);
        return longint'($signed(camera_regs[idx][k*vfsc_pkg::AXIS_BITS +: vfsc_pkg::AXIS_BITS]));
    endfunction

    function automatic longint axis_dot(longint vx, longint vy, longint vz,
                                        vfsc_pkg::reg_index_t idx);
        return vx * axis_part(idx, 0) + vy * axis_part(idx, 1) + vz * axis_part(idx, 2);
    endfunction

    function automatic vfsc_pkg::cls_t classify_sphere(
        logic signed [vfsc_pkg::COORD_WIDTH-1:0] cx,
        logic signed [vfsc_pkg::COORD_WIDTH-1:0] cy,
        logic signed [vfsc_pkg::COORD_WIDTH-1:0] cz,
        logic [vfsc_pkg::RADIUS_WIDTH-1:0] rad);
        longint         vx, vy, vz, r, near_d, far_d, sy, sx, fx, fy;
        longint         depth, lat_x, lat_y, bound_x, bound_y, widen_x, widen_y;
        vfsc_pkg::cls_t cls;
        vx = longint'(cx) - longint'($signed(camera_regs[vfsc_pkg::REG_CAM_POS_X][31:0]));
        vy = longint'(cy) - longint'($signed(camera_regs[vfsc_pkg::REG_CAM_POS_Y][31:0]));
        vz = longint'(cz) - longint'($signed(camera_regs[vfsc_pkg::REG_CAM_POS_Z][31:0]));
        r = longint'(rad);
        near_d = longint'(camera_regs[vfsc_pkg::REG_NEAR_FAR][31:0]);
        far_d = longint'(camera_regs[vfsc_pkg::REG_NEAR_FAR][63:32]);
        sy = longint'(camera_regs[vfsc_pkg::REG_SLOPES_FACTORS][15:0]);
        sx = longint'(camera_regs[vfsc_pkg::REG_SLOPES_FACTORS][31:16]);
        fx = longint'(camera_regs[vfsc_pkg::REG_SLOPES_FACTORS][47:32]);
        fy = longint'(camera_regs[vfsc_pkg::REG_SLOPES_FACTORS][63:48]);
        depth = (-axis_dot(vx, vy, vz, vfsc_pkg::REG_BACK_AXIS)) >>> vfsc_pkg::AXIS_FRAC;
        lat_x = (axis_dot(vx, vy, vz, vfsc_pkg::REG_RIGHT_AXIS) >>> vfsc_pkg::AXIS_FRAC) *
                (longint'(1) << vfsc_pkg::SLOPE_FRAC);
        lat_y = (axis_dot(vx, vy, vz, vfsc_pkg::REG_UP_AXIS) >>> vfsc_pkg::AXIS_FRAC) *
                (longint'(1) << vfsc_pkg::SLOPE_FRAC);
        bound_x = depth * sx;
        bound_y = depth * sy;
        widen_x = fx * r;
        widen_y = fy * r;
        cls = vfsc_pkg::CLS_INSIDE;
        if (depth > far_d + r || depth < near_d - r)
            cls = vfsc_pkg::CLS_OUTSIDE;
        else if (lat_x > bound_x + widen_x || lat_x < -bound_x - widen_x)
            cls = vfsc_pkg::CLS_OUTSIDE;
        else if (lat_y > bound_y + widen_y || lat_y < -bound_y - widen_y)
            cls = vfsc_pkg::CLS_OUTSIDE;
        else if (depth > far_d - r || depth < near_d + r ||
                 lat_y > bound_y - widen_y || lat_y < -bound_y + widen_y ||
                 lat_x > bound_x - widen_x || lat_x < -bound_x + widen_x)
            cls = vfsc_pkg::CLS_INTERSECT;
        return cls;
    endfunction

    function automatic longint rand_between(longint lo, longint hi);
        return lo + (longint'($urandom) % (hi - lo + 1));
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR %0t ns: %s", $time, msg);
        err_count++;
    endtask

    task automatic write_reg(vfsc_pkg::reg_index_t idx, logic [63:0] data);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            vfsc_pkg::REG_CAM_POS_X, vfsc_pkg::REG_CAM_POS_Y, vfsc_pkg::REG_CAM_POS_Z:
                camera_regs[idx] = {32'b0, data[31:0]};
            vfsc_pkg::REG_RIGHT_AXIS, vfsc_pkg::REG_UP_AXIS, vfsc_pkg::REG_BACK_AXIS:
                camera_regs[idx] = {4'b0, data[59:0]};
            default:
                camera_regs[idx] = data;
        endcase
    endtask

    task automatic set_idling(idle_mode_t mode);
        sender_idle_pct = (mode == IDLE_SENDER) ? 74 : (mode == IDLE_BOTH) ? 6 : 0;
        recv_stall_pct = (mode == IDLE_RECEIVER) ? 74 : (mode == IDLE_BOTH) ? 6 : 0;
    endtask

    task automatic wait_drained();
        sphere_ch.valid = 1'b0;
        while (expected_cls.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic send_request(logic signed [vfsc_pkg::COORD_WIDTH-1:0] cx,
                                logic signed [vfsc_pkg::COORD_WIDTH-1:0] cy,
                                logic signed [vfsc_pkg::COORD_WIDTH-1:0] cz,
                                logic [vfsc_pkg::RADIUS_WIDTH-1:0] rad,
                                logic typed, vfsc_pkg::cls_t cls);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            sphere_ch.valid = 1'b0;
            @(negedge clk);
        end
        sphere_ch.valid = 1'b1;
        sphere_ch.center_x = cx;
        sphere_ch.center_y = cy;
        sphere_ch.center_z = cz;
        sphere_ch.radius = rad;
        hold_typed = typed;
        hold_cls = cls;
        @(posedge clk);
        while (!sphere_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Builds the sphere in camera space around the frustum and maps it back
    // to world coordinates through the programmed axes.
    task automatic send_aimed_request();
        longint far_d, sx, sy, d, r, lim_x, lim_y, px, py, wx, wy, wz;
        far_d = longint'(camera_regs[vfsc_pkg::REG_NEAR_FAR][63:32]);
        sy = longint'(camera_regs[vfsc_pkg::REG_SLOPES_FACTORS][15:0]);
        sx = longint'(camera_regs[vfsc_pkg::REG_SLOPES_FACTORS][31:16]);
        d = rand_between(-(far_d / 8), far_d + far_d / 4);
        r = ($urandom_range(0, 4) == 0) ? 0 : rand_between(0, far_d / 10);
        lim_x = ((((d < 0) ? -d : d) * sx) >>> vfsc_pkg::SLOPE_FRAC) * 3 / 2 + 2 * r + 1;
        lim_y = ((((d < 0) ? -d : d) * sy) >>> vfsc_pkg::SLOPE_FRAC) * 3 / 2 + 2 * r + 1;
        px = rand_between(-lim_x, lim_x);
        py = rand_between(-lim_y, lim_y);
        wx = longint'($signed(camera_regs[vfsc_pkg::REG_CAM_POS_X][31:0])) +
             ((px * axis_part(vfsc_pkg::REG_RIGHT_AXIS, 0) +
               py * axis_part(vfsc_pkg::REG_UP_AXIS, 0) -
               d * axis_part(vfsc_pkg::REG_BACK_AXIS, 0)) >>> vfsc_pkg::AXIS_FRAC);
        wy = longint'($signed(camera_regs[vfsc_pkg::REG_CAM_POS_Y][31:0])) +
             ((px * axis_part(vfsc_pkg::REG_RIGHT_AXIS, 1) +
               py * axis_part(vfsc_pkg::REG_UP_AXIS, 1) -
               d * axis_part(vfsc_pkg::REG_BACK_AXIS, 1)) >>> vfsc_pkg::AXIS_FRAC);
        wz = longint'($signed(camera_regs[vfsc_pkg::REG_CAM_POS_Z][31:0])) +
             ((px * axis_part(vfsc_pkg::REG_RIGHT_AXIS, 2) +
               py * axis_part(vfsc_pkg::REG_UP_AXIS, 2) -
               d * axis_part(vfsc_pkg::REG_BACK_AXIS, 2)) >>> vfsc_pkg::AXIS_FRAC);
        send_request(wx[31:0], wy[31:0], wz[31:0], r[30:0], 1'b0, vfsc_pkg::CLS_OUTSIDE);
    endtask

    task automatic program_reference_camera();
        write_reg(vfsc_pkg::REG_CAM_POS_X, 64'd0);
        write_reg(vfsc_pkg::REG_CAM_POS_Y, 64'd0);
        write_reg(vfsc_pkg::REG_CAM_POS_Z, 64'd0);
        write_reg(vfsc_pkg::REG_RIGHT_AXIS, 64'h0000_0000_0004_0000);
        write_reg(vfsc_pkg::REG_UP_AXIS, 64'h0000_0040_0000_0000);
        write_reg(vfsc_pkg::REG_BACK_AXIS, 64'h0400_0000_0000_0000);
        write_reg(vfsc_pkg::REG_NEAR_FAR, {32'h0064_0000, 32'h0001_0000});
        write_reg(vfsc_pkg::REG_SLOPES_FACTORS, {16'h16A1, 16'h16A1, 16'h1000, 16'h1000});
    endtask

    task automatic program_camera(camera_kind_t kind);
        logic [59:0] packed_axis;
        longint      comp;
        int          rot;
        rot = $urandom_range(0, 2);
        case (kind)
            CAM_EXTREME_HIGH:
            begin
                write_reg(vfsc_pkg::REG_CAM_POS_X, 64'h7FFF_FFFF);
                write_reg(vfsc_pkg::REG_CAM_POS_Y, 64'h7FFF_FFFF);
                write_reg(vfsc_pkg::REG_CAM_POS_Z, 64'h7FFF_FFFF);
                write_reg(vfsc_pkg::REG_RIGHT_AXIS, {4'b0, {3{20'h7FFFF}}});
                write_reg(vfsc_pkg::REG_UP_AXIS, {4'b0, {3{20'h7FFFF}}});
                write_reg(vfsc_pkg::REG_BACK_AXIS, {4'b0, {3{20'h7FFFF}}});
                write_reg(vfsc_pkg::REG_NEAR_FAR, {32'hFFFF_FFFF, 32'h0});
                write_reg(vfsc_pkg::REG_SLOPES_FACTORS, 64'hFFFF_FFFF_FFFF_FFFF);
            end
            CAM_EXTREME_LOW:
            begin
                write_reg(vfsc_pkg::REG_CAM_POS_X, 64'h8000_0000);
                write_reg(vfsc_pkg::REG_CAM_POS_Y, 64'h8000_0000);
                write_reg(vfsc_pkg::REG_CAM_POS_Z, 64'h8000_0000);
                write_reg(vfsc_pkg::REG_RIGHT_AXIS, {4'b0, {3{20'h80000}}});
                write_reg(vfsc_pkg::REG_UP_AXIS, {4'b0, {3{20'h80000}}});
                write_reg(vfsc_pkg::REG_BACK_AXIS, {4'b0, {3{20'h80000}}});
                write_reg(vfsc_pkg::REG_NEAR_FAR, {32'h0, 32'hFFFF_FFFF});
                write_reg(vfsc_pkg::REG_SLOPES_FACTORS, 64'd0);
            end
            CAM_RAW:
            begin
                for (int i = 0; i < 8; i++)
                    write_reg(vfsc_pkg::reg_index_t'(i), {$urandom, $urandom});
            end
            default:
            begin
                write_reg(vfsc_pkg::REG_CAM_POS_X, {32'b0, $urandom});
                write_reg(vfsc_pkg::REG_CAM_POS_Y, {32'b0, $urandom});
                write_reg(vfsc_pkg::REG_CAM_POS_Z, {32'b0, $urandom});
                for (int a = 0; a < 3; a++)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        comp = rand_between(-4096, 4096);
                        if (k == (rot + a) % 3)
                            comp += ($urandom_range(0, 1) != 0) ? -262144 : 262144;
                        packed_axis[k*vfsc_pkg::AXIS_BITS +: vfsc_pkg::AXIS_BITS] = comp[19:0];
                    end
                    write_reg(vfsc_pkg::reg_index_t'(vfsc_pkg::REG_RIGHT_AXIS + a),
                              {4'b0, packed_axis});
                end
                comp = $urandom_range(32'h1000, 32'h4_0000);
                write_reg(vfsc_pkg::REG_NEAR_FAR,
                          {comp[31:0] + 32'($urandom_range(32'h1_0000, 32'hC8_0000)),
                           comp[31:0]});
                write_reg(vfsc_pkg::REG_SLOPES_FACTORS,
                          {16'($urandom_range(16'h1000, 16'h3400)),
                           16'($urandom_range(16'h1000, 16'h3400)),
                           16'($urandom_range(16'h0400, 16'h3000)),
                           16'($urandom_range(16'h0400, 16'h3000))});
            end
        endcase
    endtask

    always @(negedge clk)
    begin
        result_ch.ready = ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sphere_ch.valid && sphere_ch.ready)
                expected_cls.push_back(hold_typed ? hold_cls :
                                       classify_sphere(sphere_ch.center_x, sphere_ch.center_y,
                                                       sphere_ch.center_z, sphere_ch.radius));
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_cls.size() == 0)
                    report_mismatch($sformatf("classification %0d with no request pending",
                                              result_ch.classification));
                else
                begin
                    expected_head = expected_cls.pop_front();
                    if (result_ch.classification !== expected_head)
                        report_mismatch($sformatf("classification %0d, expected %0d",
                                                  result_ch.classification, expected_head));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        logic aimed_on;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sphere_ch.valid = 1'b0;
        sphere_ch.center_x = '0;
        sphere_ch.center_y = '0;
        sphere_ch.center_z = '0;
        sphere_ch.radius = '0;
        hold_typed = 1'b0;
        hold_cls = vfsc_pkg::CLS_OUTSIDE;
        aimed_on = 1'b0;
        for (int i = 0; i < 8; i++)
            camera_regs[i] = 64'd0;
        set_idling(IDLE_NONE);
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].aimed_camera != aimed_on)
            begin
                wait_drained();
                program_reference_camera();
                aimed_on = 1'b1;
            end
            send_request(directed_rows[i].cx, directed_rows[i].cy, directed_rows[i].cz,
                         directed_rows[i].rad, directed_rows[i].typed, directed_rows[i].cls);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_drained();
            if (p < 2)
                program_camera(camera_kind_t'(p));
            else if (p % 4 == 3)
                program_camera(CAM_RAW);
            else
                program_camera(CAM_AIMED);
            set_idling(idle_mode_t'(p % 4));
            for (int n = 0; n < REQUESTS_PER_PHASE; n++)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_request($urandom, $urandom, $urandom, 31'($urandom), 1'b0,
                                 vfsc_pkg::CLS_OUTSIDE);
                else
                    send_aimed_request();
            end
        end

        wait_drained();
        if (err_count == 0 && expected_cls.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### sim.f
sv/vfsc_pkg.sv
sv/vfsc_if.sv
sv/view_frustum_sphere_classifier.sv
sv/vfsc_checker.sv
dv/tb_view_frustum_sphere_classifier.sv
